// ===== rtl/cgm_pkg.sv =====
// Shared types and constants for the confidence grid map unit.
// Used by cgm_div, cgm_datapath, cgm_ctrl and confidence_grid_map_unit; depends on nothing.
package cgm_pkg;

	// Fixed field widths.
	localparam int COORD_W  = 24;
	localparam int CS_W     = 16;
	localparam int DIM_W    = 7;
	localparam int DEPTH_W  = 16;
	localparam int CONF_W   = 16;
	localparam int ACT_W    = 2;
	localparam int CFG_IDX_W = 3;

	// Divider: the dividend magnitude is one bit wider than a coordinate,
	// the signed quotient one bit wider again.
	localparam int DIVD_W     = COORD_W + 1;
	localparam int QUO_W      = DIVD_W + 1;
	localparam int DIV_STEPS  = DIVD_W;
	localparam int DIV_CNT_W  = 5;

	// Action codes.
	localparam logic [ACT_W-1:0] ACT_QUERY = 2'd0;
	localparam logic [ACT_W-1:0] ACT_DEPTH = 2'd1;
	localparam logic [ACT_W-1:0] ACT_OBST  = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd4;

	// Configuration reset values.
	localparam logic [CS_W-1:0]  CELL_SIZE_RST = 16'd256;
	localparam logic [DIM_W-1:0] WIDTH_RST     = 7'd64;
	localparam logic [DIM_W-1:0] HEIGHT_RST    = 7'd64;

	// One map cell as held in the cell memory.
	typedef struct packed {
		logic [DEPTH_W-1:0] depth;
		logic [CONF_W-1:0]  depth_conf;
		logic               obst;
		logic [CONF_W-1:0]  obst_conf;
	} cell_ent_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clr_wr;
		logic cap_in;
		logic div_start;
		logic div_sel_y;
		logic cap_col;
		logic cap_row;
		logic mul_en;
		logic idx_en;
		logic rd_en;
		logic upd_en;
	} cgm_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clr_last;
		logic div_done;
		logic out_busy;
	} cgm_stat_t;

endpackage

// ===== rtl/cgm_div.sv =====
// Restoring divider, one quotient bit per cycle, for coordinate / cell size.
// Depends on cgm_pkg.
module cgm_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [cgm_pkg::DIVD_W-1:0] dividend_mag,
	input  logic                      neg,
	input  logic [cgm_pkg::CS_W-1:0]  divisor,
	output logic                      done,
	output logic signed [cgm_pkg::QUO_W-1:0] quotient
);
	import cgm_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic                 neg_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [CS_W-1:0]      rem_q;
	logic [DIVD_W-1:0]    quo_q;
	logic [CS_W-1:0]      div_q;

	logic [CS_W:0] shifted;
	logic          ge;
	logic [CS_W:0] diff;

	assign shifted = {rem_q, quo_q[DIVD_W-1]};
	assign ge      = shifted >= {1'b0, div_q};
	assign diff    = shifted - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend_mag;
			div_q <= divisor;
			neg_q <= neg;
		end else if (busy_q) begin
			rem_q <= ge ? diff[CS_W-1:0] : shifted[CS_W-1:0];
			quo_q <= {quo_q[DIVD_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

endmodule

// ===== rtl/cgm_datapath.sv =====
// Datapath of the grid map: configuration registers, cell index arithmetic,
// cell memory and result register. Depends on cgm_pkg and cgm_div.
module cgm_datapath #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cgm_pkg::cgm_cmd_t             cmd,
	output cgm_pkg::cgm_stat_t            stat,
	input  logic                          cfg_wr_en,
	input  logic [cgm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [cgm_pkg::COORD_W-1:0]   cfg_data,
	input  logic [cgm_pkg::ACT_W-1:0]     action,
	input  logic signed [cgm_pkg::COORD_W-1:0] x_pos,
	input  logic signed [cgm_pkg::COORD_W-1:0] y_pos,
	input  logic signed [cgm_pkg::DEPTH_W-1:0] new_depth,
	input  logic                          obstacle_flag,
	input  logic [cgm_pkg::CONF_W-1:0]    new_confidence,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          in_range,
	output logic                          written,
	output logic signed [cgm_pkg::DEPTH_W-1:0] depth_out,
	output logic                          depth_valid,
	output logic                          obstacle_out
);
	import cgm_pkg::*;

	localparam int CELLS  = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW     = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int WW     = $clog2(MAX_WIDTH + 1);
	localparam int HW     = $clog2(MAX_HEIGHT + 1);
	localparam int AREA_W = WW + HW;
	localparam int PW     = QUO_W + WW + 1;
	localparam int IW     = PW + 1;

	// Configuration registers.
	logic signed [COORD_W-1:0] origin_x_q, origin_y_q;
	logic [CS_W-1:0]           cell_size_q;
	logic [DIM_W-1:0]          width_cells_q, height_cells_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q     <= '0;
			origin_y_q     <= '0;
			cell_size_q    <= CELL_SIZE_RST;
			width_cells_q  <= WIDTH_RST;
			height_cells_q <= HEIGHT_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_ORIGIN_X:  origin_x_q     <= cfg_data;
				REG_ORIGIN_Y:  origin_y_q     <= cfg_data;
				REG_CELL_SIZE: cell_size_q    <= cfg_data[CS_W-1:0];
				REG_WIDTH:     width_cells_q  <= cfg_data[DIM_W-1:0];
				REG_HEIGHT:    height_cells_q <= cfg_data[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	// Transaction fields held for the whole item.
	logic [ACT_W-1:0]          act_q;
	logic signed [COORD_W-1:0] x_q, y_q;
	logic [DEPTH_W-1:0]        depth_q;
	logic                      obst_q;
	logic [CONF_W-1:0]         conf_q;

	always_ff @(posedge clk) begin
		if (cmd.cap_in) begin
			act_q   <= action;
			x_q     <= x_pos;
			y_q     <= y_pos;
			depth_q <= new_depth;
			obst_q  <= obstacle_flag;
			conf_q  <= new_confidence;
		end
	end

	// Shared divider; the controller runs it for x, then for y.
	logic signed [DIVD_W-1:0] div_sum;
	logic [DIVD_W-1:0]        div_mag;
	logic                     div_done;
	logic signed [QUO_W-1:0]  quo;

	assign div_sum = cmd.div_sel_y ? (DIVD_W'(y_q) + DIVD_W'(origin_y_q))
	                               : (DIVD_W'(x_q) + DIVD_W'(origin_x_q));
	assign div_mag = div_sum[DIVD_W-1] ? DIVD_W'(-div_sum) : DIVD_W'(div_sum);

	cgm_div u_div (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (cmd.div_start),
		.dividend_mag (div_mag),
		.neg          (div_sum[DIVD_W-1]),
		.divisor      (cell_size_q),
		.done         (div_done),
		.quotient     (quo)
	);

	logic signed [QUO_W-1:0] col_q, row_q;

	always_ff @(posedge clk) begin
		if (cmd.cap_col) col_q <= quo;
		if (cmd.cap_row) row_q <= quo;
	end

	// Grid size in use, clamped to the storage.
	logic [WW-1:0] w_use;
	logic [HW-1:0] h_use;

	assign w_use = (int'(width_cells_q) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(width_cells_q);
	assign h_use = (int'(height_cells_q) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(height_cells_q);

	logic signed [PW-1:0] row_ext, w_ext, prod_q;
	logic [AREA_W-1:0]    w_area, h_area, area_q;

	assign row_ext = PW'(row_q);
	assign w_ext   = $signed(PW'(w_use));
	assign w_area  = AREA_W'(w_use);
	assign h_area  = AREA_W'(h_use);

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_q <= row_ext * w_ext;
			area_q <= w_area * h_area;
		end
	end

	// Linear index and range test.
	logic signed [IW-1:0] id_sum;
	logic                 id_ok;
	logic [AW-1:0]        idx_q;
	logic                 inr_q;

	assign id_sum = IW'(prod_q) + IW'(col_q);
	assign id_ok  = (cell_size_q != '0) && !id_sum[IW-1]
	             && (id_sum[IW-2:0] < (IW-1)'(area_q));

	always_ff @(posedge clk) begin
		if (cmd.idx_en) begin
			idx_q <= id_sum[AW-1:0];
			inr_q <= id_ok;
		end
	end

	// Cell memory with registered read and a clearing pass after reset.
	cell_ent_t     mem_q [CELLS];
	cell_ent_t     rd_ent_q;
	logic [AW-1:0] clr_addr_q;
	logic          mem_we;
	logic [AW-1:0] mem_wa;
	cell_ent_t     mem_wd;
	cell_ent_t     upd_ent;
	logic          do_wr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clr_wr) begin
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	assign stat.clr_last = clr_addr_q == AW'(CELLS - 1);

	always_comb begin
		upd_ent = rd_ent_q;
		do_wr   = 1'b0;
		if (act_q == ACT_DEPTH && conf_q > rd_ent_q.depth_conf) begin
			upd_ent.depth      = depth_q;
			upd_ent.depth_conf = conf_q;
			do_wr              = inr_q;
		end else if (act_q == ACT_OBST && conf_q > rd_ent_q.obst_conf) begin
			upd_ent.obst      = obst_q;
			upd_ent.obst_conf = conf_q;
			do_wr             = inr_q;
		end
	end

	assign mem_we = cmd.clr_wr || (cmd.upd_en && do_wr);
	assign mem_wa = cmd.clr_wr ? clr_addr_q : idx_q;
	assign mem_wd = cmd.clr_wr ? cell_ent_t'('0) : upd_ent;

	always_ff @(posedge clk) begin
		if (mem_we) mem_q[mem_wa] <= mem_wd;
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) rd_ent_q <= mem_q[idx_q];
	end

	// Result register.
	logic               out_valid_q;
	logic               in_range_q, written_q, depth_valid_q, obstacle_out_q;
	logic [DEPTH_W-1:0] depth_out_q;
	logic               dval, oval;

	assign dval = inr_q && (upd_ent.depth_conf != '0);
	assign oval = inr_q && (upd_ent.obst_conf != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.upd_en) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.upd_en) begin
			in_range_q     <= inr_q;
			written_q      <= do_wr;
			depth_valid_q  <= dval;
			depth_out_q    <= dval ? upd_ent.depth : '0;
			obstacle_out_q <= oval && upd_ent.obst;
		end
	end

	assign stat.div_done = div_done;
	assign stat.out_busy = out_valid_q && !out_ready;

	assign out_valid    = out_valid_q;
	assign in_range     = in_range_q;
	assign written      = written_q;
	assign depth_out    = depth_out_q;
	assign depth_valid  = depth_valid_q;
	assign obstacle_out = obstacle_out_q;

endmodule

// ===== rtl/cgm_ctrl.sv =====
// Controller state machine of the grid map: sequences clearing, the two
// divisions, multiply, index, read and update. Depends on cgm_pkg.
module cgm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  cgm_pkg::cgm_stat_t  stat,
	output cgm_pkg::cgm_cmd_t   cmd
);
	import cgm_pkg::*;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIVX_GO,
		ST_DIVX,
		ST_DIVY_GO,
		ST_DIVY,
		ST_MUL,
		ST_INDEX,
		ST_READ,
		ST_UPDATE
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			case (state_q)
				ST_CLEAR:   if (stat.clr_last) state_q <= ST_IDLE;
				ST_IDLE:    if (in_valid) state_q <= ST_DIVX_GO;
				ST_DIVX_GO: state_q <= ST_DIVX;
				ST_DIVX:    if (stat.div_done) state_q <= ST_DIVY_GO;
				ST_DIVY_GO: state_q <= ST_DIVY;
				ST_DIVY:    if (stat.div_done) state_q <= ST_MUL;
				ST_MUL:     state_q <= ST_INDEX;
				ST_INDEX:   state_q <= ST_READ;
				ST_READ:    state_q <= ST_UPDATE;
				ST_UPDATE:  if (!stat.out_busy) state_q <= ST_IDLE;
				default:    state_q <= ST_CLEAR;
			endcase
		end
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_CLEAR:   cmd.clr_wr = 1'b1;
			ST_IDLE:    cmd.cap_in = in_valid;
			ST_DIVX_GO: cmd.div_start = 1'b1;
			ST_DIVX:    cmd.cap_col = stat.div_done;
			ST_DIVY_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel_y = 1'b1;
			end
			ST_DIVY:    cmd.cap_row = stat.div_done;
			ST_MUL:     cmd.mul_en = 1'b1;
			ST_INDEX:   cmd.idx_en = 1'b1;
			ST_READ:    cmd.rd_en = 1'b1;
			ST_UPDATE:  cmd.upd_en = !stat.out_busy;
			default:    cmd = '0;
		endcase
	end

	assign in_ready = state_q == ST_IDLE;

endmodule

// ===== rtl/confidence_grid_map_unit.sv =====
// Top level of the confidence grid map unit.
// Depends on cgm_pkg, cgm_ctrl, cgm_datapath and cgm_div.

// The unit keeps a max-confidence occupancy grid of MAX_WIDTH by MAX_HEIGHT
// cells, each holding a depth with its confidence and an obstacle flag with
// its confidence. After reset the unit clears all MAX_WIDTH * MAX_HEIGHT cells
// (4096 with the default sizes) of the cell memory, one cell per cycle,
// and holds in_ready low meanwhile; configuration writes are taken at any time.
// It then works on one transaction at a time. A single restoring divider,
// one quotient bit per cycle, turns x and then y into a column and a row.
// Each division is a start step, 25 quotient steps and a done step. Separate
// states then follow for the index multiply, the range test, the memory read
// and the read-modify-write of the cell. in_ready rises again in the same
// cycle in which the result appears. The result sits in an output register,
// so the next transaction is accepted while the previous result still
// waits. A result that is still waiting holds the following transaction in
// its final update cycle.
// Configuration registers must only be written while the unit is idle.

module confidence_grid_map_unit #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Configuration write port.
	input  logic                          cfg_wr_en,
	input  logic [cgm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [cgm_pkg::COORD_W-1:0]   cfg_data,
	// Input channel.
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [cgm_pkg::ACT_W-1:0]     action,
	input  logic signed [cgm_pkg::COORD_W-1:0] x_pos,
	input  logic signed [cgm_pkg::COORD_W-1:0] y_pos,
	input  logic signed [cgm_pkg::DEPTH_W-1:0] new_depth,
	input  logic                          obstacle_flag,
	input  logic [cgm_pkg::CONF_W-1:0]    new_confidence,
	// Result channel.
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          in_range,
	output logic                          written,
	output logic signed [cgm_pkg::DEPTH_W-1:0] depth_out,
	output logic                          depth_valid,
	output logic                          obstacle_out
);
	import cgm_pkg::*;

	cgm_cmd_t  cmd;
	cgm_stat_t stat;

	// The controller sequences each transaction; all arithmetic and storage
	// live in the datapath.
	cgm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	cgm_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.action         (action),
		.x_pos          (x_pos),
		.y_pos          (y_pos),
		.new_depth      (new_depth),
		.obstacle_flag  (obstacle_flag),
		.new_confidence (new_confidence),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.in_range       (in_range),
		.written        (written),
		.depth_out      (depth_out),
		.depth_valid    (depth_valid),
		.obstacle_out   (obstacle_out)
	);

	// Only one transaction is in flight, so acceptance drops in_ready.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("in_ready stayed high after a transaction was accepted");

	// A cell outside the grid is never written and reads as empty.
	a_out_of_range_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !in_range |-> !written && !depth_valid && !obstacle_out
		&& depth_out == '0)
		else $error("out-of-range result is not empty");

	// A depth without confidence reads as zero.
	a_invalid_depth_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !depth_valid |-> depth_out == '0)
		else $error("depth_out nonzero while depth_valid is low");

	// A successful write is in range, and its depth is either valid or zero.
	a_written_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && written |-> in_range && (depth_valid || $countones(depth_out) == 0))
		else $error("written result without a valid cell");

endmodule

// ===== bench/cgm_checker.sv =====
`timescale 1ns / 1ps
// Result checker for confidence_grid_map_unit: keeps its own copy of the map and its settings,
// predicts the cell view for every accepted transaction and compares results in order.
// Depends on cgm_pkg.

module cgm_checker #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [cgm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [cgm_pkg::COORD_W-1:0]         cfg_data,
	input  logic                                in_valid,
	input  logic                                in_ready,
	input  logic [cgm_pkg::ACT_W-1:0]           action,
	input  logic signed [cgm_pkg::COORD_W-1:0]  x_pos,
	input  logic signed [cgm_pkg::COORD_W-1:0]  y_pos,
	input  logic signed [cgm_pkg::DEPTH_W-1:0]  new_depth,
	input  logic                                obstacle_flag,
	input  logic [cgm_pkg::CONF_W-1:0]          new_confidence,
	input  logic                                out_valid,
	input  logic                                out_ready,
	input  logic                                in_range,
	input  logic                                written,
	input  logic signed [cgm_pkg::DEPTH_W-1:0]  depth_out,
	input  logic                                depth_valid,
	input  logic                                obstacle_out,
	output int                                  fail_count,
	output int                                  waiting
);
	import cgm_pkg::*;

	localparam int GRID_CELLS = MAX_WIDTH * MAX_HEIGHT;

	typedef struct packed {
		logic                      in_range;
		logic                      written;
		logic signed [DEPTH_W-1:0] depth;
		logic                      depth_valid;
		logic                      obstacle;
	} map_view_t;

	logic signed [COORD_W-1:0] org_x, org_y;
	logic [CS_W-1:0]           cell_sz;
	logic [DIM_W-1:0]          cols_cfg, rows_cfg;

	logic signed [DEPTH_W-1:0] depth_mem      [GRID_CELLS];
	logic [CONF_W-1:0]         depth_conf_mem [GRID_CELLS];
	logic                      obst_mem       [GRID_CELLS];
	logic [CONF_W-1:0]         obst_conf_mem  [GRID_CELLS];

	map_view_t expected_views[$];
	map_view_t want;
	int        errs;

	// Applies one transaction to the mirrored map and returns the cell as it stands after it.
	function automatic map_view_t update_cell(input logic [ACT_W-1:0] act,
			input logic signed [COORD_W-1:0] x, input logic signed [COORD_W-1:0] y,
			input logic signed [DEPTH_W-1:0] nd, input logic nob, input logic [CONF_W-1:0] nc);
		map_view_t view;
		longint cols, rows, col, row, slot;
		view = '0;
		cols = (cols_cfg > MAX_WIDTH) ? longint'(MAX_WIDTH) : longint'(cols_cfg);
		rows = (rows_cfg > MAX_HEIGHT) ? longint'(MAX_HEIGHT) : longint'(rows_cfg);
		if (cell_sz == '0)
			return view;
		// SystemVerilog division of signed operands truncates toward zero.
		col = (longint'(x) + longint'(org_x)) / longint'(cell_sz);
		row = (longint'(y) + longint'(org_y)) / longint'(cell_sz);
		slot = row * cols + col;
		if (slot < 0 || slot >= cols * rows)
			return view;
		view.in_range = 1'b1;
		if (act == ACT_DEPTH && nc > depth_conf_mem[slot]) begin
			depth_mem[slot] = nd;
			depth_conf_mem[slot] = nc;
			view.written = 1'b1;
		end else if (act == ACT_OBST && nc > obst_conf_mem[slot]) begin
			obst_mem[slot] = nob;
			obst_conf_mem[slot] = nc;
			view.written = 1'b1;
		end
		if (depth_conf_mem[slot] != '0) begin
			view.depth = depth_mem[slot];
			view.depth_valid = 1'b1;
		end
		if (obst_conf_mem[slot] != '0)
			view.obstacle = obst_mem[slot];
		return view;
	endfunction

	task automatic check_field(input string name, input int exp_val, input int got_val);
		if (exp_val != got_val) begin
			$error("%s mismatch: expected %0d, actual %0d", name, exp_val, got_val);
			errs++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			org_x = '0;
			org_y = '0;
			cell_sz = CELL_SIZE_RST;
			cols_cfg = WIDTH_RST;
			rows_cfg = HEIGHT_RST;
			for (int i = 0; i < GRID_CELLS; i++) begin
				depth_mem[i] = '0;
				depth_conf_mem[i] = '0;
				obst_mem[i] = 1'b0;
				obst_conf_mem[i] = '0;
			end
			expected_views.delete();
			errs = 0;
			fail_count <= 0;
			waiting <= 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_ORIGIN_X: org_x = cfg_data;
					REG_ORIGIN_Y: org_y = cfg_data;
					REG_CELL_SIZE: cell_sz = cfg_data[CS_W-1:0];
					REG_WIDTH: cols_cfg = cfg_data[DIM_W-1:0];
					REG_HEIGHT: rows_cfg = cfg_data[DIM_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				expected_views.insert(expected_views.size(), update_cell(action, x_pos,
					y_pos, new_depth, obstacle_flag, new_confidence));
			if (out_valid && out_ready) begin
				if (expected_views.size() == 0) begin
					$error("result transaction arrived with no expectation pending");
					errs++;
				end else begin
					want = expected_views.pop_front();
					check_field("in_range", int'(want.in_range), int'(in_range));
					check_field("written", int'(want.written), int'(written));
					check_field("depth_out", int'(want.depth), int'(depth_out));
					check_field("depth_valid", int'(want.depth_valid), int'(depth_valid));
					check_field("obstacle_out", int'(want.obstacle), int'(obstacle_out));
				end
			end
			fail_count <= errs;
			waiting <= expected_views.size();
		end
	end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Top of the confidence_grid_map_unit testbench: clock, reset, stimulus, verdict.
// Depends on cgm_pkg, confidence_grid_map_unit and cgm_checker.

module tb;
	import cgm_pkg::*;

	// Action code 3 is unused by the unit and must behave like a query.
	localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;

	// The unit clears 4096 cells after reset and then handles one transaction at a
	// time, so a quiet stretch this long can only mean a hang.
	localparam int STALL_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 100;

	logic clk = 1'b0;
	logic arst_n;

	logic                      cfg_wr_en;
	logic [CFG_IDX_W-1:0]      cfg_index;
	logic [COORD_W-1:0]        cfg_data;
	logic                      in_valid;
	logic                      in_ready;
	logic [ACT_W-1:0]          action;
	logic signed [COORD_W-1:0] x_pos;
	logic signed [COORD_W-1:0] y_pos;
	logic signed [DEPTH_W-1:0] new_depth;
	logic                      obstacle_flag;
	logic [CONF_W-1:0]         new_confidence;
	logic                      out_valid;
	logic                      out_ready;
	logic                      in_range;
	logic                      written;
	logic signed [DEPTH_W-1:0] depth_out;
	logic                      depth_valid;
	logic                      obstacle_out;

	int fail_count;
	int waiting;
	int stall_cycles;

	// When steady is set neither side idles; it is flipped with nonblocking
	// assignments so that both stimulus processes see it change at the same edge.
	logic steady;

	// Stimulus keeps the current map settings so it can aim coordinates at the grid.
	int cur_ox, cur_oy, cur_cs, cur_w, cur_h;

	confidence_grid_map_unit dut (.*);

	cgm_checker checker_i (.*);

	always #5 clk = ~clk;

	// The result side drops ready at random with a six percent chance.
	always @(posedge clk)
		out_ready <= steady || ($urandom_range(99) >= 6);

	// Watchdog: any cycle in which neither channel completes a transaction counts
	// toward the limit; a hang or a lost result ends the run here.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles == STALL_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	// Offers one input transaction and returns at the edge where it is taken.
	// Valid is left high on return so that back-to-back transactions never
	// lower and raise it within one time step.
	task automatic send_fields(input logic [ACT_W-1:0] act, input int x, input int y,
			input int nd, input logic ob, input int nc);
		while (!steady && $urandom_range(99) < 6) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		x_pos <= x[COORD_W-1:0];
		y_pos <= y[COORD_W-1:0];
		new_depth <= nd[DEPTH_W-1:0];
		obstacle_flag <= ob;
		new_confidence <= nc[CONF_W-1:0];
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// Stops offering input and waits until every predicted result has been seen.
	// The checker's count is registered, hence the first step.
	task automatic settle_map();
		in_valid <= 1'b0;
		@(posedge clk);
		while (waiting != 0)
			@(posedge clk);
	endtask

	// Writes all five registers on consecutive edges; the unit must be idle.
	task automatic set_map(input int ox, input int oy, input int cs, input int w, input int h);
		int vals[5];
		logic [CFG_IDX_W-1:0] regs[5];
		vals[0] = ox;
		vals[1] = oy;
		vals[2] = cs;
		vals[3] = w;
		vals[4] = h;
		regs[0] = REG_ORIGIN_X;
		regs[1] = REG_ORIGIN_Y;
		regs[2] = REG_CELL_SIZE;
		regs[3] = REG_WIDTH;
		regs[4] = REG_HEIGHT;
		cur_ox = ox;
		cur_oy = oy;
		cur_cs = cs;
		cur_w = (w > 64) ? 64 : w;
		cur_h = (h > 64) ? 64 : h;
		for (int i = 0; i < 5; i++) begin
			cfg_wr_en <= 1'b1;
			cfg_index <= regs[i];
			cfg_data <= vals[i][COORD_W-1:0];
			@(posedge clk);
		end
		cfg_wr_en <= 1'b0;
	endtask

	// Picks a coordinate that lands mostly on or just around the grid, with a
	// bias toward a few cells near the origin so that repeated updates compete
	// on confidence. One pick in five is a raw 24-bit value to exercise every bit.
	function automatic int aim_coord(input int n_cells, input int org, input int size);
		int span, pick;
		longint target;
		logic [31:0] raw;
		span = (size < 1) ? 1 : size;
		if (n_cells < 1)
			n_cells = 1;
		raw = $urandom();
		if ($urandom_range(99) < 20)
			return int'($signed(raw[COORD_W-1:0]));
		pick = int'($urandom_range(n_cells + 3)) - 2;
		if ($urandom_range(99) < 30)
			pick = int'($urandom_range((n_cells < 3) ? n_cells - 1 : 2));
		target = longint'(pick) * span - longint'(org) + longint'($urandom_range(span - 1));
		if (target < -8388608 || target > 8388607)
			return int'($signed(raw[COORD_W-1:0]));
		return int'(target);
	endfunction

	task automatic run_random(input int n);
		int r, nc;
		logic [ACT_W-1:0] act;
		repeat (n) begin
			r = $urandom_range(99);
			if (r < 20)
				act = ACT_QUERY;
			else if (r < 25)
				act = ACT_SPARE;
			else if (r < 62)
				act = ACT_DEPTH;
			else
				act = ACT_OBST;
			r = $urandom_range(99);
			if (r < 10)
				nc = 0;
			else if (r < 15)
				nc = 65535;
			else if (r < 45)
				nc = $urandom_range(255);
			else
				nc = $urandom_range(65535);
			send_fields(act, aim_coord(cur_w, cur_ox, cur_cs), aim_coord(cur_h, cur_oy, cur_cs),
				int'($urandom_range(65535)), logic'($urandom_range(1)), nc);
		end
	endtask

	// A new phase starts only once the unit has delivered every pending result,
	// which also serves as the sender pausing until the pipe is empty.
	task automatic next_phase(input int ox, input int oy, input int cs, input int w,
			input int h, input int n);
		settle_map();
		set_map(ox, oy, cs, w, h);
		run_random(n);
	endtask

	initial begin
		arst_n <= 1'b0;
		steady <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= REG_ORIGIN_X;
		cfg_data <= '0;
		in_valid <= 1'b0;
		action <= ACT_QUERY;
		x_pos <= '0;
		y_pos <= '0;
		new_depth <= '0;
		obstacle_flag <= 1'b0;
		new_confidence <= '0;
		out_ready <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Default geometry written explicitly: 1 m cells, 64 by 64, no offset.
		// The unit is still clearing its memory, and writes are legal meanwhile.
		set_map(0, 0, 256, 64, 64);

		// Directed transactions on the default grid.
		send_fields(ACT_QUERY, 0, 0, 0, 1'b0, 0);              // cleared cell reads empty
		send_fields(ACT_DEPTH, 0, 0, 32767, 1'b0, 0);          // zero confidence never writes
		send_fields(ACT_DEPTH, 0, 0, 32767, 1'b0, 1);          // first real write
		send_fields(ACT_DEPTH, 0, 0, -32768, 1'b0, 1);         // equal confidence loses
		send_fields(ACT_DEPTH, 0, 0, -32768, 1'b0, 65535);     // stronger one wins
		send_fields(ACT_OBST, 0, 0, 0, 1'b1, 0);
		send_fields(ACT_OBST, 0, 0, 0, 1'b1, 5);
		send_fields(ACT_OBST, 0, 0, 0, 1'b0, 5);
		send_fields(ACT_SPARE, 0, 0, 123, 1'b1, 65535);        // unused code is a query
		send_fields(ACT_QUERY, -256, 0, 0, 1'b0, 0);           // linear index -1
		send_fields(ACT_DEPTH, -255, 0, 77, 1'b0, 7);          // truncates toward column 0
		send_fields(ACT_DEPTH, 16384, 0, 4660, 1'b0, 9);       // column 64 wraps to row 1
		send_fields(ACT_QUERY, 0, 256, 0, 1'b0, 0);            // same cell seen from row 1
		send_fields(ACT_OBST, -512, 512, 0, 1'b1, 100);        // column -2 wraps back a row
		send_fields(ACT_DEPTH, 16128, 16128, -1, 1'b0, 65535); // last cell of the grid
		send_fields(ACT_DEPTH, 16384, 16128, 1, 1'b0, 65535);  // one past the last cell
		send_fields(ACT_DEPTH, 8388607, 8388607, 1, 1'b1, 65535);
		send_fields(ACT_OBST, -8388608, -8388608, 1, 1'b1, 65535);
		send_fields(ACT_QUERY, 8388607, -8388608, 0, 1'b0, 0);
		send_fields(ACT_DEPTH, 1280, 0, 0, 1'b0, 65535);       // stored depth of zero is valid
		send_fields(ACT_OBST, 0, 0, 0, 1'b0, 65535);           // obstacle cleared with confidence
		run_random(120);

		// Extreme origins with the finest grid and a single cell.
		next_phase(-8388608, 8388607, 1, 1, 1, 40);
		// Coarsest cells; a width past the maximum is clamped.
		next_phase(1000, -500, 65535, 127, 64, 60);
		// Zero cell size and zero height: everything is outside.
		next_phase(0, 0, 0, 3, 0, 20);
		// Zero width: the grid is empty.
		next_phase(-300, 700, 256, 0, 5, 20);
		// Tiny grid so that updates keep landing on the same cells.
		next_phase(300, -1234, 100, 5, 3, 150);
		// A long stretch with neither side idling; height is clamped here.
		settle_map();
		steady <= 1'b1;
		next_phase(-40000, 25000, 37, 64, 127, 100);
		settle_map();
		steady <= 1'b0;
		next_phase(8388607, -8388608, 65535, 64, 64, 40);

		settle_map();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
